// File: rtl/msgpack_token_decoder_macros.svh
// assertion macros for the msgpack token decoder
// no dependencies; included by the modules that carry assertions
`ifndef MSGPACK_TOKEN_DECODER_MACROS_SVH
`define MSGPACK_TOKEN_DECODER_MACROS_SVH

// same-cycle implication
`define MTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mtd_pkg.sv
// shared types, codes and format-byte decode for the msgpack token decoder
// no dependencies
package mtd_pkg;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		KIND_NIL     = 4'd0,
		KIND_BOOL    = 4'd1,
		KIND_UINT    = 4'd2,
		KIND_INT     = 4'd3,
		KIND_FLOAT   = 4'd4,
		KIND_STR     = 4'd5,
		KIND_BIN     = 4'd6,
		KIND_ARRAY   = 4'd7,
		KIND_MAP     = 4'd8,
		KIND_PAYLOAD = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_FORMAT    = 2'd1,
		ERR_TRUNCATED = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ACT_EMIT    = 2'd0,
		ACT_FIELD   = 2'd1,
		ACT_PAYLOAD = 2'd2,
		ACT_ERROR   = 2'd3
	} fmt_act_t;

	localparam logic [7:0] FMT_NIL     = 8'hC0;
	localparam logic [7:0] FMT_FALSE   = 8'hC2;
	localparam logic [7:0] FMT_TRUE    = 8'hC3;
	localparam logic [7:0] FMT_BIN8    = 8'hC4;
	localparam logic [7:0] FMT_BIN16   = 8'hC5;
	localparam logic [7:0] FMT_BIN32   = 8'hC6;
	localparam logic [7:0] FMT_FLOAT32 = 8'hCA;
	localparam logic [7:0] FMT_FLOAT64 = 8'hCB;
	localparam logic [7:0] FMT_UINT8   = 8'hCC;
	localparam logic [7:0] FMT_UINT16  = 8'hCD;
	localparam logic [7:0] FMT_UINT32  = 8'hCE;
	localparam logic [7:0] FMT_UINT64  = 8'hCF;
	localparam logic [7:0] FMT_INT8    = 8'hD0;
	localparam logic [7:0] FMT_INT16   = 8'hD1;
	localparam logic [7:0] FMT_INT32   = 8'hD2;
	localparam logic [7:0] FMT_INT64   = 8'hD3;
	localparam logic [7:0] FMT_STR8    = 8'hD9;
	localparam logic [7:0] FMT_STR16   = 8'hDA;
	localparam logic [7:0] FMT_STR32   = 8'hDB;
	localparam logic [7:0] FMT_ARRAY16 = 8'hDC;
	localparam logic [7:0] FMT_ARRAY32 = 8'hDD;
	localparam logic [7:0] FMT_MAP16   = 8'hDE;
	localparam logic [7:0] FMT_MAP32   = 8'hDF;

	localparam logic [3:0] SIZE_1 = 4'd1;
	localparam logic [3:0] SIZE_2 = 4'd2;
	localparam logic [3:0] SIZE_4 = 4'd4;
	localparam logic [3:0] SIZE_8 = 4'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		kind_t       token_kind;
		logic [63:0] value;
		logic        float_is_double;
		logic        payload_last;
		err_t        error_code;
	} res_t;

	typedef struct packed {
		fmt_act_t    act;
		kind_t       kind;
		logic [3:0]  size;
		logic [63:0] value;
	} fmt_t;

	function automatic fmt_t fmt_decode(input logic [7:0] b);
		fmt_t f;
		f.act   = ACT_EMIT;
		f.kind  = KIND_NIL;
		f.size  = 4'd0;
		f.value = 64'd0;
		if (b[7] == 1'b0) begin
			f.kind  = KIND_UINT;
			f.value = {56'd0, b};
		end else if (b[7:5] == 3'b111) begin
			f.kind  = KIND_INT;
			f.value = {{56{1'b1}}, b};
		end else if (b[7:4] == 4'h8) begin
			f.kind  = KIND_MAP;
			f.value = {60'd0, b[3:0]};
		end else if (b[7:4] == 4'h9) begin
			f.kind  = KIND_ARRAY;
			f.value = {60'd0, b[3:0]};
		end else if (b[7:5] == 3'b101) begin
			f.act   = ACT_PAYLOAD;
			f.kind  = KIND_STR;
			f.value = {59'd0, b[4:0]};
		end else begin
			unique case (b)
				FMT_NIL: f.kind = KIND_NIL;
				FMT_FALSE: f.kind = KIND_BOOL;
				FMT_TRUE: begin
					f.kind  = KIND_BOOL;
					f.value = 64'd1;
				end
				FMT_BIN8: begin f.act = ACT_FIELD; f.kind = KIND_BIN; f.size = SIZE_1; end
				FMT_BIN16: begin f.act = ACT_FIELD; f.kind = KIND_BIN; f.size = SIZE_2; end
				FMT_BIN32: begin f.act = ACT_FIELD; f.kind = KIND_BIN; f.size = SIZE_4; end
				FMT_FLOAT32: begin f.act = ACT_FIELD; f.kind = KIND_FLOAT; f.size = SIZE_4; end
				FMT_FLOAT64: begin f.act = ACT_FIELD; f.kind = KIND_FLOAT; f.size = SIZE_8; end
				FMT_UINT8: begin f.act = ACT_FIELD; f.kind = KIND_UINT; f.size = SIZE_1; end
				FMT_UINT16: begin f.act = ACT_FIELD; f.kind = KIND_UINT; f.size = SIZE_2; end
				FMT_UINT32: begin f.act = ACT_FIELD; f.kind = KIND_UINT; f.size = SIZE_4; end
				FMT_UINT64: begin f.act = ACT_FIELD; f.kind = KIND_UINT; f.size = SIZE_8; end
				FMT_INT8: begin f.act = ACT_FIELD; f.kind = KIND_INT; f.size = SIZE_1; end
				FMT_INT16: begin f.act = ACT_FIELD; f.kind = KIND_INT; f.size = SIZE_2; end
				FMT_INT32: begin f.act = ACT_FIELD; f.kind = KIND_INT; f.size = SIZE_4; end
				FMT_INT64: begin f.act = ACT_FIELD; f.kind = KIND_INT; f.size = SIZE_8; end
				FMT_STR8: begin f.act = ACT_FIELD; f.kind = KIND_STR; f.size = SIZE_1; end
				FMT_STR16: begin f.act = ACT_FIELD; f.kind = KIND_STR; f.size = SIZE_2; end
				FMT_STR32: begin f.act = ACT_FIELD; f.kind = KIND_STR; f.size = SIZE_4; end
				FMT_ARRAY16: begin f.act = ACT_FIELD; f.kind = KIND_ARRAY; f.size = SIZE_2; end
				FMT_ARRAY32: begin f.act = ACT_FIELD; f.kind = KIND_ARRAY; f.size = SIZE_4; end
				FMT_MAP16: begin f.act = ACT_FIELD; f.kind = KIND_MAP; f.size = SIZE_2; end
				FMT_MAP32: begin f.act = ACT_FIELD; f.kind = KIND_MAP; f.size = SIZE_4; end
				default: begin
					f.act   = ACT_ERROR;
					f.value = {56'd0, b};
				end
			endcase
		end
		return f;
	endfunction

endpackage

// File: rtl/mtd_byte_if.sv
// valid/ready channel carrying one byte of the encoded buffer
// no dependencies
interface mtd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/mtd_token_if.sv
// valid/ready channel carrying one decoded token
// no dependencies
interface mtd_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [63:0] value;
	logic        float_is_double;
	logic        payload_last;
	logic [1:0]  error_code;

	modport source (output valid, output token_kind, output value, output float_is_double,
		output payload_last, output error_code, input ready);
	modport sink (input valid, input token_kind, input value, input float_is_double,
		input payload_last, input error_code, output ready);
endinterface

// File: rtl/mtd_in_stage.sv
// input register stage of the msgpack token decoder
// depends on mtd_pkg
module mtd_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  mtd_pkg::item_t in_item,
	output logic          in_ready,
	input  logic          advance,
	output logic          valid_s1,
	output mtd_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/mtd_decode_core.sv
// token decode state machine: one byte in, at most one token out per cycle in which fire is high
// depends on mtd_pkg and msgpack_token_decoder_macros.svh
`include "msgpack_token_decoder_macros.svh"

module mtd_decode_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  mtd_pkg::item_t item,
	output logic           emit,
	output mtd_pkg::res_t  res
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_FIELD   = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	phase_t          phase_q, phase_d;
	mtd_pkg::kind_t  kind_q, kind_d;
	logic [3:0]      size_q, size_d;
	logic [3:0]      left_q, left_d;
	logic [63:0]     acc_q, acc_d;
	logic [31:0]     plen_q, plen_d;

	mtd_pkg::fmt_t   fmt;
	logic [63:0]     acc_shift;
	logic [3:0]      left_dec;
	logic [63:0]     field_val;
	logic            pl_final;
	logic            sp_go;
	mtd_pkg::kind_t  sp_kind;
	logic [31:0]     sp_len;
	logic            go_idle;

	always_comb begin
		fmt       = mtd_pkg::fmt_decode(item.data_byte);
		acc_shift = {acc_q[55:0], item.data_byte};
		left_dec  = (left_q != 4'd0) ? (left_q - 4'd1) : left_q;
		pl_final  = (plen_q <= 32'd1);
		field_val = acc_shift;
		if (kind_q == mtd_pkg::KIND_INT) begin
			case (size_q)
				mtd_pkg::SIZE_1: field_val = {{56{acc_shift[7]}}, acc_shift[7:0]};
				mtd_pkg::SIZE_2: field_val = {{48{acc_shift[15]}}, acc_shift[15:0]};
				mtd_pkg::SIZE_4: field_val = {{32{acc_shift[31]}}, acc_shift[31:0]};
				default: field_val = acc_shift;
			endcase
		end

		phase_d = phase_q;
		kind_d  = kind_q;
		size_d  = size_q;
		left_d  = left_q;
		acc_d   = acc_q;
		plen_d  = plen_q;
		emit    = 1'b0;
		res     = '{token_kind: mtd_pkg::KIND_NIL, value: 64'd0, float_is_double: 1'b0,
			payload_last: 1'b0, error_code: mtd_pkg::ERR_NONE};
		sp_go   = 1'b0;
		sp_kind = mtd_pkg::KIND_STR;
		sp_len  = 32'd0;
		go_idle = 1'b0;

		if (fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					unique case (fmt.act)
						mtd_pkg::ACT_EMIT: begin
							emit           = 1'b1;
							res.token_kind = fmt.kind;
							res.value      = fmt.value;
						end
						mtd_pkg::ACT_FIELD: begin
							if (item.last_byte) begin
								emit           = 1'b1;
								res.error_code = mtd_pkg::ERR_TRUNCATED;
							end else begin
								phase_d = PH_FIELD;
								kind_d  = fmt.kind;
								size_d  = fmt.size;
								left_d  = fmt.size;
								acc_d   = 64'd0;
							end
						end
						mtd_pkg::ACT_PAYLOAD: begin
							sp_go   = 1'b1;
							sp_kind = fmt.kind;
							sp_len  = fmt.value[31:0];
						end
						mtd_pkg::ACT_ERROR: begin
							emit           = 1'b1;
							res.value      = fmt.value;
							res.error_code = mtd_pkg::ERR_FORMAT;
						end
						default: ;
					endcase
				end
				PH_FIELD: begin
					acc_d  = acc_shift;
					left_d = left_dec;
					if (left_dec == 4'd0) begin
						if (kind_q == mtd_pkg::KIND_STR || kind_q == mtd_pkg::KIND_BIN) begin
							sp_go   = 1'b1;
							sp_kind = kind_q;
							sp_len  = acc_shift[31:0];
						end else begin
							go_idle        = 1'b1;
							emit           = 1'b1;
							res.token_kind = kind_q;
							res.value      = field_val;
							res.float_is_double = (kind_q == mtd_pkg::KIND_FLOAT) &&
								(size_q == mtd_pkg::SIZE_8);
						end
					end else if (item.last_byte) begin
						go_idle        = 1'b1;
						emit           = 1'b1;
						res.error_code = mtd_pkg::ERR_TRUNCATED;
					end
				end
				PH_PAYLOAD: begin
					emit = 1'b1;
					if (item.last_byte && !pl_final) begin
						go_idle        = 1'b1;
						res.error_code = mtd_pkg::ERR_TRUNCATED;
					end else begin
						res.token_kind   = mtd_pkg::KIND_PAYLOAD;
						res.value        = {56'd0, item.data_byte};
						res.payload_last = pl_final;
						if (pl_final) begin
							go_idle = 1'b1;
						end else begin
							plen_d = plen_q - 32'd1;
						end
					end
				end
				default: go_idle = 1'b1;
			endcase

			// string or binary header
			if (sp_go) begin
				go_idle = 1'b1;
				emit    = 1'b1;
				if (sp_len == 32'd0) begin
					res.token_kind = sp_kind;
				end else if (item.last_byte) begin
					res.error_code = mtd_pkg::ERR_TRUNCATED;
				end else begin
					res.token_kind = sp_kind;
					res.value      = {32'd0, sp_len};
				end
			end

			if (go_idle) begin
				phase_d = PH_IDLE;
				kind_d  = mtd_pkg::KIND_NIL;
				size_d  = 4'd0;
				left_d  = 4'd0;
				acc_d   = 64'd0;
				plen_d  = 32'd0;
				if (sp_go && sp_len != 32'd0 && !item.last_byte) begin
					phase_d = PH_PAYLOAD;
					plen_d  = sp_len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= mtd_pkg::KIND_NIL;
			size_q  <= 4'd0;
			left_q  <= 4'd0;
			acc_q   <= 64'd0;
			plen_q  <= 32'd0;
		end else begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			size_q  <= size_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			plen_q  <= plen_d;
		end
	end

	`MTD_ASSERT_NOW(a_field_left, clk, arst_n, phase_q == PH_FIELD, left_q != 4'd0, "field phase with no bytes left")
	`MTD_ASSERT_NOW(a_payload_left, clk, arst_n, phase_q == PH_PAYLOAD, plen_q != 32'd0, "payload phase with zero length")
	`MTD_ASSERT_NOW(a_err_kind, clk, arst_n, emit && res.error_code != mtd_pkg::ERR_NONE, res.token_kind == mtd_pkg::KIND_NIL && !res.payload_last, "error token with kind set")

endmodule

// File: rtl/mtd_out_queue.sv
// result queue between the decode core and the token channel
// depends on mtd_pkg and msgpack_token_decoder_macros.svh
`include "msgpack_token_decoder_macros.svh"

module mtd_out_queue #(
	parameter int Depth = mtd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mtd_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output mtd_pkg::res_t out_data
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	mtd_pkg::res_t     mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              pop;

	assign full      = (count_q == CntW'(Depth));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`MTD_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full, "push into full result queue")
	`MTD_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + CntW'(1), "queue count did not follow push")

endmodule

// File: rtl/msgpack_token_decoder.sv
// msgpack token decoder top level: input register, decode core, result queue
// depends on mtd_pkg, mtd_byte_if, mtd_token_if, mtd_in_stage, mtd_decode_core,
// mtd_out_queue
//
// usage:
//   byte_chan takes the encoded buffer one byte per request, last_byte marking
//   the final byte of a buffer. token_chan gives one decoded token per request:
//   nil, bool, integers, float bits, string/binary/array/map headers and
//   string/binary payload bytes, or an error token.
//   a byte is registered at its request edge and decoded from the input
//   register while the result queue has room; its token, if any, goes into the
//   result queue. throughput is one byte per clock while the queue is not full,
//   bounded by the single decode stage. bytes inside multi-byte fields make no
//   token, so tokens come at most one per byte.
//   reset empties the input register and the result queue and returns the
//   decoder to waiting for a format byte.
//   when token_chan stalls, up to QueueDepth tokens wait in the queue and one
//   more byte in the input register; then byte_chan.ready goes low until the
//   receiver takes a token.
module msgpack_token_decoder #(
	parameter int QueueDepth = mtd_pkg::QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	mtd_byte_if.sink    byte_chan,
	mtd_token_if.source token_chan
);

	mtd_pkg::item_t in_item;
	mtd_pkg::item_t item_s1;
	logic           valid_s1;
	logic           advance;
	logic           q_full;
	logic           emit;
	mtd_pkg::res_t  res;
	mtd_pkg::res_t  out_data;

	assign in_item.data_byte = byte_chan.data_byte;
	assign in_item.last_byte = byte_chan.last_byte;
	assign advance           = valid_s1 && !q_full;

	mtd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_chan.valid),
		.in_item  (in_item),
		.in_ready (byte_chan.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mtd_decode_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	mtd_out_queue #(
		.Depth (QueueDepth)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (res),
		.full      (q_full),
		.out_valid (token_chan.valid),
		.out_ready (token_chan.ready),
		.out_data  (out_data)
	);

	assign token_chan.token_kind      = out_data.token_kind;
	assign token_chan.value           = out_data.value;
	assign token_chan.float_is_double = out_data.float_is_double;
	assign token_chan.payload_last    = out_data.payload_last;
	assign token_chan.error_code      = out_data.error_code;

endmodule

// File: tb/tb_msgpack_token_decoder.sv
`timescale 1ns / 100ps
// self-checking testbench for msgpack_token_decoder: directed table, then random buffers
// depends on mtd_pkg, mtd_byte_if, mtd_token_if and the decoder rtl
module tb_msgpack_token_decoder;

	localparam logic [7:0] POSFIX_HI      = 8'h7F;
	localparam logic [7:0] FIXMAP_LO      = 8'h80;
	localparam logic [7:0] FIXARRAY_HI    = 8'h9F;
	localparam logic [7:0] FIXSTR         = 8'hA0;
	localparam logic [7:0] NEGFIX_LO      = 8'hE0;
	localparam logic [7:0] FMT_NEVER_USED = 8'hC1;
	localparam logic [7:0] FMT_EXT8       = 8'hC7;
	localparam logic [7:0] FMT_FIXEXT1    = 8'hD4;

	typedef enum logic [2:0] {
		DEC_IDLE    = 3'b001,
		DEC_FIELD   = 3'b010,
		DEC_PAYLOAD = 3'b100
	} dec_phase_t;

	typedef struct {
		logic [7:0]    b;
		bit            lst;
		bit            typed;
		mtd_pkg::res_t tok;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	mtd_byte_if  byte_chan ();
	mtd_token_if token_chan ();

	msgpack_token_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_chan  (byte_chan),
		.token_chan (token_chan)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// decoder state mirror
	dec_phase_t     dec_phase;
	mtd_pkg::kind_t fld_kind;
	int unsigned    fld_size;
	int unsigned    fld_left;
	logic [63:0]    fld_acc;
	logic [31:0]    pay_left;

	mtd_pkg::res_t tokens_due[$];
	int            bad_tokens = 0;
	int            tokens_taken = 0;
	int            burst_left = 0;
	mtd_pkg::res_t seen;
	mtd_pkg::res_t want;

	function automatic mtd_pkg::res_t token(mtd_pkg::kind_t k, logic [63:0] v, bit dbl,
		bit pl, mtd_pkg::err_t e);
		mtd_pkg::res_t t;
		t.token_kind      = k;
		t.value           = v;
		t.float_is_double = dbl;
		t.payload_last    = pl;
		t.error_code      = e;
		return t;
	endfunction

	// plain token with no error
	function automatic mtd_pkg::res_t tok_ok(mtd_pkg::kind_t k, logic [63:0] v);
		return token(k, v, 1'b0, 1'b0, mtd_pkg::ERR_NONE);
	endfunction

	// error token
	function automatic mtd_pkg::res_t tok_err(mtd_pkg::err_t e, logic [63:0] v);
		return token(mtd_pkg::KIND_NIL, v, 1'b0, 1'b0, e);
	endfunction

	function automatic void clear_decoder();
		dec_phase = DEC_IDLE;
		fld_kind  = mtd_pkg::KIND_NIL;
		fld_size  = 0;
		fld_left  = 0;
		fld_acc   = '0;
		pay_left  = '0;
	endfunction

	function automatic bit begin_field(mtd_pkg::kind_t k, int unsigned n, bit lst,
		output mtd_pkg::res_t r);
		clear_decoder();
		if (lst) begin
			r = tok_err(mtd_pkg::ERR_TRUNCATED, '0);
			return 1'b1;
		end
		dec_phase = DEC_FIELD;
		fld_kind  = k;
		fld_size  = n;
		fld_left  = n;
		return 1'b0;
	endfunction

	function automatic bit open_payload(mtd_pkg::kind_t k, logic [31:0] len, bit lst,
		output mtd_pkg::res_t r);
		clear_decoder();
		if (len == 0) begin
			r = tok_ok(k, '0);
			return 1'b1;
		end
		if (lst) begin
			r = tok_err(mtd_pkg::ERR_TRUNCATED, '0);
			return 1'b1;
		end
		dec_phase = DEC_PAYLOAD;
		pay_left  = len;
		r = tok_ok(k, {32'd0, len});
		return 1'b1;
	endfunction

	function automatic bit finish_field(bit lst, output mtd_pkg::res_t r);
		mtd_pkg::kind_t k;
		int unsigned    n;
		logic [63:0]    v;
		k = fld_kind;
		n = fld_size;
		v = fld_acc;
		if (k == mtd_pkg::KIND_STR || k == mtd_pkg::KIND_BIN)
			return open_payload(k, v[31:0], lst, r);
		clear_decoder();
		if (k == mtd_pkg::KIND_INT && n < 8 && v[8*n-1])
			v = v | ({64{1'b1}} << (8*n));
		r = token(k, v, (k == mtd_pkg::KIND_FLOAT) && (n == 8), 1'b0, mtd_pkg::ERR_NONE);
		return 1'b1;
	endfunction

	// one byte into the mirror, returns 1 when a token comes out
	function automatic bit decode_byte(input logic [7:0] b, input bit lst,
		output mtd_pkg::res_t r);
		bit             fin;
		mtd_pkg::kind_t k;
		int unsigned    n;
		case (dec_phase)
			DEC_FIELD: begin
				fld_acc = {fld_acc[55:0], b};
				if (fld_left > 0)
					fld_left--;
				if (fld_left == 0)
					return finish_field(lst, r);
				if (lst) begin
					clear_decoder();
					r = tok_err(mtd_pkg::ERR_TRUNCATED, '0);
					return 1'b1;
				end
				return 1'b0;
			end
			DEC_PAYLOAD: begin
				fin = (pay_left <= 1);
				if (lst && !fin) begin
					clear_decoder();
					r = tok_err(mtd_pkg::ERR_TRUNCATED, '0);
					return 1'b1;
				end
				if (fin)
					clear_decoder();
				else
					pay_left--;
				r = token(mtd_pkg::KIND_PAYLOAD, {56'd0, b}, 1'b0, fin, mtd_pkg::ERR_NONE);
				return 1'b1;
			end
			default: begin
				clear_decoder();
				if (!b[7]) begin
					r = tok_ok(mtd_pkg::KIND_UINT, {56'd0, b});
					return 1'b1;
				end
				if (b[7:5] == 3'b111) begin
					r = tok_ok(mtd_pkg::KIND_INT, {{56{1'b1}}, b});
					return 1'b1;
				end
				if (b[7:4] == 4'h8) begin
					r = tok_ok(mtd_pkg::KIND_MAP, {60'd0, b[3:0]});
					return 1'b1;
				end
				if (b[7:4] == 4'h9) begin
					r = tok_ok(mtd_pkg::KIND_ARRAY, {60'd0, b[3:0]});
					return 1'b1;
				end
				if (b[7:5] == 3'b101)
					return open_payload(mtd_pkg::KIND_STR, {27'd0, b[4:0]}, lst, r);
				k = mtd_pkg::KIND_NIL;
				n = 0;
				case (b)
					mtd_pkg::FMT_NIL:     r = tok_ok(mtd_pkg::KIND_NIL, '0);
					mtd_pkg::FMT_FALSE:   r = tok_ok(mtd_pkg::KIND_BOOL, '0);
					mtd_pkg::FMT_TRUE:    r = tok_ok(mtd_pkg::KIND_BOOL, 64'd1);
					mtd_pkg::FMT_BIN8:    begin k = mtd_pkg::KIND_BIN; n = 1; end
					mtd_pkg::FMT_BIN16:   begin k = mtd_pkg::KIND_BIN; n = 2; end
					mtd_pkg::FMT_BIN32:   begin k = mtd_pkg::KIND_BIN; n = 4; end
					mtd_pkg::FMT_FLOAT32: begin k = mtd_pkg::KIND_FLOAT; n = 4; end
					mtd_pkg::FMT_FLOAT64: begin k = mtd_pkg::KIND_FLOAT; n = 8; end
					mtd_pkg::FMT_UINT8:   begin k = mtd_pkg::KIND_UINT; n = 1; end
					mtd_pkg::FMT_UINT16:  begin k = mtd_pkg::KIND_UINT; n = 2; end
					mtd_pkg::FMT_UINT32:  begin k = mtd_pkg::KIND_UINT; n = 4; end
					mtd_pkg::FMT_UINT64:  begin k = mtd_pkg::KIND_UINT; n = 8; end
					mtd_pkg::FMT_INT8:    begin k = mtd_pkg::KIND_INT; n = 1; end
					mtd_pkg::FMT_INT16:   begin k = mtd_pkg::KIND_INT; n = 2; end
					mtd_pkg::FMT_INT32:   begin k = mtd_pkg::KIND_INT; n = 4; end
					mtd_pkg::FMT_INT64:   begin k = mtd_pkg::KIND_INT; n = 8; end
					mtd_pkg::FMT_STR8:    begin k = mtd_pkg::KIND_STR; n = 1; end
					mtd_pkg::FMT_STR16:   begin k = mtd_pkg::KIND_STR; n = 2; end
					mtd_pkg::FMT_STR32:   begin k = mtd_pkg::KIND_STR; n = 4; end
					mtd_pkg::FMT_ARRAY16: begin k = mtd_pkg::KIND_ARRAY; n = 2; end
					mtd_pkg::FMT_ARRAY32: begin k = mtd_pkg::KIND_ARRAY; n = 4; end
					mtd_pkg::FMT_MAP16:   begin k = mtd_pkg::KIND_MAP; n = 2; end
					mtd_pkg::FMT_MAP32:   begin k = mtd_pkg::KIND_MAP; n = 4; end
					default:              r = tok_err(mtd_pkg::ERR_FORMAT, {56'd0, b});
				endcase
				if (n != 0)
					return begin_field(k, n, lst, r);
				return 1'b1;
			end
		endcase
	endfunction

	function automatic row_t row(logic [7:0] b, bit lst);
		row_t x;
		x.b     = b;
		x.lst   = lst;
		x.typed = 1'b0;
		x.tok   = '0;
		return x;
	endfunction

	function automatic row_t row_typed(logic [7:0] b, bit lst, mtd_pkg::res_t tok);
		row_t x;
		x = row(b, lst);
		x.typed = 1'b1;
		x.tok   = tok;
		return x;
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'h80 << (8 * $urandom_range(0, 7));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void put_be(ref logic [7:0] frame[$], input logic [63:0] v,
		input int n);
		for (int i = n - 1; i >= 0; i--)
			frame.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put_payload(ref logic [7:0] frame[$], input int n);
		for (int i = 0; i < n; i++)
			frame.push_back(8'($urandom_range(0, 255)));
	endfunction

	// appends one encoded item, returns 1 if the buffer has to end right after it
	function automatic bit gen_item(ref logic [7:0] frame[$]);
		int          idx;
		int          len;
		logic [7:0]  fmt;
		logic [31:0] big;
		case ($urandom_range(0, 15))
			0, 12: frame.push_back(8'($urandom_range(0, POSFIX_HI)));
			1: frame.push_back(8'($urandom_range(NEGFIX_LO, 8'hFF)));
			2: frame.push_back(8'($urandom_range(FIXMAP_LO, FIXARRAY_HI)));
			3: begin
				case ($urandom_range(0, 2))
					0: frame.push_back(mtd_pkg::FMT_NIL);
					1: frame.push_back(mtd_pkg::FMT_FALSE);
					default: frame.push_back(mtd_pkg::FMT_TRUE);
				endcase
			end
			4, 13: begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
					: $urandom_range(0, 4);
				frame.push_back(FIXSTR | 8'(len));
				put_payload(frame, len);
			end
			5, 14: begin
				idx = $urandom_range(0, 3);
				frame.push_back(mtd_pkg::FMT_UINT8 + 8'(idx));
				put_be(frame, rand_word(), 1 << idx);
			end
			6: begin
				idx = $urandom_range(0, 3);
				frame.push_back(mtd_pkg::FMT_INT8 + 8'(idx));
				put_be(frame, rand_word(), 1 << idx);
			end
			7: begin
				idx = $urandom_range(0, 1);
				frame.push_back(idx ? mtd_pkg::FMT_FLOAT64 : mtd_pkg::FMT_FLOAT32);
				put_be(frame, rand_word(), idx ? 8 : 4);
			end
			8, 15: begin
				idx = $urandom_range(0, 2);
				fmt = $urandom_range(0, 1) ? mtd_pkg::FMT_STR8 : mtd_pkg::FMT_BIN8;
				len = $urandom_range(0, 9);
				frame.push_back(fmt + 8'(idx));
				put_be(frame, len, 1 << idx);
				put_payload(frame, len);
			end
			9: begin
				fmt = mtd_pkg::FMT_ARRAY16 + 8'($urandom_range(0, 3));
				frame.push_back(fmt);
				put_be(frame, rand_word(),
					(fmt == mtd_pkg::FMT_ARRAY16 || fmt == mtd_pkg::FMT_MAP16) ? 2 : 4);
			end
			10: begin
				case ($urandom_range(0, 2))
					0: frame.push_back(FMT_NEVER_USED);
					1: frame.push_back(FMT_EXT8 + 8'($urandom_range(0, 2)));
					default: frame.push_back(FMT_FIXEXT1 + 8'($urandom_range(0, 4)));
				endcase
			end
			default: begin
				// long length, cut short by the end of the buffer
				idx = $urandom_range(1, 2);
				fmt = $urandom_range(0, 1) ? mtd_pkg::FMT_STR8 : mtd_pkg::FMT_BIN8;
				big = (idx == 1) ? $urandom_range(40, 16'hFFFF)
					: $urandom_range(40, 32'hFFFF_FFFF);
				frame.push_back(fmt + 8'(idx));
				put_be(frame, big, 1 << idx);
				put_payload(frame, $urandom_range(0, 5));
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit lst, input bit typed,
		input mtd_pkg::res_t tok);
		mtd_pkg::res_t pred;
		bit            has;
		if (burst_left == 0) begin
			byte_chan.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 150)
				: $urandom_range(1, 10);
		end
		byte_chan.valid     <= 1'b1;
		byte_chan.data_byte <= b;
		byte_chan.last_byte <= lst;
		@(posedge clk);
		while (!byte_chan.ready)
			@(posedge clk);
		burst_left--;
		has = decode_byte(b, lst, pred);
		if (typed)
			tokens_due.push_back(tok);
		else if (has)
			tokens_due.push_back(pred);
	endtask

	task automatic wait_drained();
		byte_chan.valid <= 1'b0;
		@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
	endtask

	// token checker
	always @(posedge clk) begin
		if (arst_n && token_chan.valid && token_chan.ready) begin
			seen.token_kind      = mtd_pkg::kind_t'(token_chan.token_kind);
			seen.value           = token_chan.value;
			seen.float_is_double = token_chan.float_is_double;
			seen.payload_last    = token_chan.payload_last;
			seen.error_code      = mtd_pkg::err_t'(token_chan.error_code);
			tokens_taken++;
			if (tokens_due.size() == 0) begin
				bad_tokens++;
				if (bad_tokens <= 10)
					$display("unexpected token: kind %0d value %h dbl %b plast %b err %0d",
						seen.token_kind, seen.value, seen.float_is_double,
						seen.payload_last, seen.error_code);
			end else begin
				want = tokens_due.pop_front();
				if (seen !== want) begin
					bad_tokens++;
					if (bad_tokens <= 10)
						$display("token mismatch: exp %0d %h %b %b %0d got %0d %h %b %b %0d",
							want.token_kind, want.value, want.float_is_double,
							want.payload_last, want.error_code, seen.token_kind,
							seen.value, seen.float_is_double, seen.payload_last,
							seen.error_code);
				end
			end
		end
	end

	// token receiver: run-length stall pattern plus one long hold-off
	initial begin : receiver
		int run_left;
		int hold_left;
		bit accepting;
		bit hold_done;
		run_left  = 0;
		hold_left = 0;
		accepting = 1'b0;
		hold_done = 1'b0;
		token_chan.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && tokens_taken >= 120) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				token_chan.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					accepting = !accepting;
					if (accepting)
						run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 12);
					else
						run_left = $urandom_range(1, 5);
				end
				run_left--;
				token_chan.ready <= accepting;
			end
		end
	end

	initial begin : stimulus
		row_t       plan[$];
		logic [7:0] frame[$];
		int         sent;
		int         cut;
		bit         ends;
		arst_n <= 1'b0;
		byte_chan.valid     <= 1'b0;
		byte_chan.data_byte <= '0;
		byte_chan.last_byte <= 1'b0;
		clear_decoder();

		plan.push_back(row_typed(8'h00, 1'b0, tok_ok(mtd_pkg::KIND_UINT, '0)));
		plan.push_back(row_typed(8'hFF, 1'b0, tok_ok(mtd_pkg::KIND_INT, '1)));
		plan.push_back(row_typed(mtd_pkg::FMT_NIL, 1'b0, tok_ok(mtd_pkg::KIND_NIL, '0)));
		plan.push_back(row_typed(mtd_pkg::FMT_TRUE, 1'b0, tok_ok(mtd_pkg::KIND_BOOL, 64'd1)));
		plan.push_back(row_typed(FMT_NEVER_USED, 1'b0,
			tok_err(mtd_pkg::ERR_FORMAT, {56'd0, FMT_NEVER_USED})));
		plan.push_back(row_typed(FMT_EXT8, 1'b0,
			tok_err(mtd_pkg::ERR_FORMAT, {56'd0, FMT_EXT8})));
		plan.push_back(row_typed(FIXARRAY_HI, 1'b0, tok_ok(mtd_pkg::KIND_ARRAY, 64'd15)));
		plan.push_back(row_typed(FIXMAP_LO, 1'b0, tok_ok(mtd_pkg::KIND_MAP, '0)));
		// empty string, empty binary, then a float32
		plan.push_back(row_typed(FIXSTR, 1'b0, tok_ok(mtd_pkg::KIND_STR, '0)));
		plan.push_back(row(mtd_pkg::FMT_BIN8, 1'b0));
		plan.push_back(row(8'h00, 1'b0));
		plan.push_back(row(mtd_pkg::FMT_FLOAT32, 1'b0));
		plan.push_back(row(8'h3F, 1'b0));
		plan.push_back(row(8'h80, 1'b0));
		plan.push_back(row(8'h00, 1'b0));
		plan.push_back(row(8'h00, 1'b0));
		// two-byte string ending the buffer cleanly
		plan.push_back(row(FIXSTR | 8'd2, 1'b0));
		plan.push_back(row(8'h41, 1'b0));
		plan.push_back(row(8'h42, 1'b1));
		// buffer ends mid-item
		plan.push_back(row_typed(mtd_pkg::FMT_UINT16, 1'b1,
			tok_err(mtd_pkg::ERR_TRUNCATED, '0)));
		plan.push_back(row_typed(FIXSTR | 8'd1, 1'b1, tok_err(mtd_pkg::ERR_TRUNCATED, '0)));
		plan.push_back(row(FIXSTR | 8'd3, 1'b0));
		plan.push_back(row_typed(8'h00, 1'b1, tok_err(mtd_pkg::ERR_TRUNCATED, '0)));
		plan.push_back(row(mtd_pkg::FMT_UINT32, 1'b0));
		plan.push_back(row_typed(8'h12, 1'b1, tok_err(mtd_pkg::ERR_TRUNCATED, '0)));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_byte(plan[i].b, plan[i].lst, plan[i].typed, plan[i].tok);
		wait_drained();

		sent = 0;
		while (sent < 750) begin
			frame.delete();
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 11) == 0) begin
					frame.push_back(8'($urandom_range(0, 255)));
				end else begin
					ends = gen_item(frame);
					if (ends)
						break;
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				cut = $urandom_range(1, frame.size());
				frame = frame[0:cut-1];
			end
			foreach (frame[i])
				send_byte(frame[i], i == frame.size() - 1, 1'b0, '0);
			sent += frame.size();
		end
		wait_drained();
		repeat (12) @(posedge clk);

		if (bad_tokens == 0 && tokens_due.size() == 0)
			$display("PASS msgpack_token_decoder");
		else
			$display("FAIL msgpack_token_decoder");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("FAIL msgpack_token_decoder");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/mtd_pkg.sv
rtl/mtd_byte_if.sv
rtl/mtd_token_if.sv
rtl/mtd_in_stage.sv
rtl/mtd_decode_core.sv
rtl/mtd_out_queue.sv
rtl/msgpack_token_decoder.sv
tb/tb_msgpack_token_decoder.sv
